// ----- rtl/fixed_decimal_text_to_int_unit_assert.svh -----
// Assertion macros for the decimal text converter.
`ifndef FIXED_DECIMAL_TEXT_TO_INT_UNIT_ASSERT_SVH
`define FIXED_DECIMAL_TEXT_TO_INT_UNIT_ASSERT_SVH

// Combinational check, sampled on every rising clock edge outside reset.
`define FDTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication into the next cycle.
`define FDTI_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/fdti_pkg.sv -----
// Shared types and constants of the decimal text converter.
`timescale 1ns / 1ps
package fdti_pkg;

  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned FracW   = 5;
  localparam int unsigned CountW  = 6;
  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  // Register indexes on the APB port (address bits [4:3]).
  localparam logic [1:0] REG_VALUE_LIMIT     = 2'd0;
  localparam logic [1:0] REG_FRACTION_DIGITS = 2'd1;
  localparam logic [1:0] REG_SIGNED_MODE     = 2'd2;

  localparam logic [ValueW-1:0] LIMIT_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FracW-1:0]  FRAC_RESET  = 5'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TWO_POINT = 3'd1,
    ST_FRAC_LEN  = 3'd2,
    ST_BAD_CHAR  = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TK_DIGIT = 2'd0,
    TK_POINT = 2'd1,
    TK_MINUS = 2'd2,  // leading minus that signed mode accepts
    TK_OTHER = 2'd3
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic       first;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [ValueW-1:0] value_limit;
    logic [FracW-1:0]  fraction_digits;
  } back_cfg_t;

endpackage

// ----- rtl/fdti_tok_fifo.sv -----
// Short token queue between the classifier and the accumulator.
`timescale 1ns / 1ps
module fdti_tok_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  fdti_pkg::token_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output fdti_pkg::token_t rd_data_o,
  output logic            empty_o
);
  import fdti_pkg::*;

  localparam logic [TokPtrW:0] DepthC = (TokPtrW+1)'(TokDepth);

  token_t             mem_q [TokDepth];
  logic [TokPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [TokPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [TokPtrW:0]   count_q, count_d;

  assign full_o    = (count_q == DepthC);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == TokPtrW'(TokDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == TokPtrW'(TokDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr_en_i, rd_en_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/fdti_front.sv -----
// Character classifier: turns each accepted character into a token.
`timescale 1ns / 1ps
module fdti_front (
  input  logic             push_i,
  input  logic             q_full_i,
  input  logic [7:0]       char_code_i,
  input  logic             first_char_i,
  input  logic             last_char_i,
  input  logic             signed_mode_i,
  output logic             q_wr_o,
  output fdti_pkg::token_t tok_o
);
  import fdti_pkg::*;

  assign q_wr_o = push_i & ~q_full_i;

  always_comb begin
    // low nibble of '0'..'9' is the digit value
    tok_o.digit = char_code_i[3:0];
    tok_o.first = first_char_i;
    tok_o.last  = last_char_i;
    priority if (char_code_i >= CH_ZERO && char_code_i <= CH_NINE) begin
      tok_o.kind = TK_DIGIT;
    end else if (char_code_i == CH_POINT) begin
      tok_o.kind = TK_POINT;
    end else if (char_code_i == CH_MINUS && first_char_i && signed_mode_i) begin
      tok_o.kind = TK_MINUS;
    end else begin
      tok_o.kind = TK_OTHER;
    end
  end

endmodule

// ----- rtl/fdti_back.sv -----
// Accumulator and status logic, with the result output register.
`timescale 1ns / 1ps
module fdti_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fdti_pkg::back_cfg_t        cfg_i,
  input  logic                       tok_valid_i,
  input  fdti_pkg::token_t           tok_i,
  output logic                       tok_pop_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [fdti_pkg::ValueW-1:0] magnitude_o,
  output logic                       negative_o,
  output fdti_pkg::status_e          status_o
);
  import fdti_pkg::*;

  logic [ValueW-1:0] acc_q, acc_d;
  logic              point_q, point_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  status_e           err_q, err_d;
  logic              ebp_q, ebp_d;
  logic              minus_q, minus_d;

  logic              res_valid_q;
  logic [ValueW-1:0] res_mag_q;
  logic              res_neg_q;
  status_e           res_st_q;

  logic [ValueW-1:0] acc0;
  logic              point0, minus0, ebp0;
  logic [CountW-1:0] cnt0;
  status_e           err0, raise_code, st;
  logic              raise_en;
  logic [ValueW+3:0] prod;
  logic              too_large;

  // A last token needs a free output slot; others go through at once.
  assign tok_pop_o = tok_valid_i & (~tok_i.last | ~res_valid_q | pop_i);

  assign empty_o     = ~res_valid_q;
  assign magnitude_o = res_mag_q;
  assign negative_o  = res_neg_q;
  assign status_o    = res_st_q;

  always_comb begin
    acc0   = tok_i.first ? '0 : acc_q;
    point0 = tok_i.first ? 1'b0 : point_q;
    cnt0   = tok_i.first ? '0 : cnt_q;
    err0   = tok_i.first ? ST_OK : err_q;
    ebp0   = tok_i.first ? 1'b0 : ebp_q;
    minus0 = tok_i.first ? 1'b0 : minus_q;

    // acc*10 + digit in 68 bits, so the limit test cannot wrap
    prod = ({4'b0, acc0} << 3) + ({4'b0, acc0} << 1) + (ValueW+4)'(tok_i.digit);
    too_large = prod > {4'b0, cfg_i.value_limit};

    acc_d      = acc0;
    point_d    = point0;
    cnt_d      = cnt0;
    minus_d    = minus0;
    raise_en   = 1'b0;
    raise_code = ST_OK;

    if (err0 != ST_OK && ebp0) begin
      // outcome fixed by an error before the point
    end else if (point0) begin
      if (cnt0 != COUNT_MAX) begin
        cnt_d = cnt0 + 1'b1;
      end
      if (err0 == ST_OK) begin
        unique case (tok_i.kind)
          TK_POINT: begin
            raise_en   = 1'b1;
            raise_code = ST_TWO_POINT;
          end
          TK_DIGIT: begin
            if (too_large) begin
              raise_en   = 1'b1;
              raise_code = ST_TOO_LARGE;
            end else begin
              acc_d = prod[ValueW-1:0];
            end
          end
          default: begin
            raise_en   = 1'b1;
            raise_code = ST_BAD_CHAR;
          end
        endcase
      end
    end else begin
      unique case (tok_i.kind)
        TK_MINUS: minus_d = 1'b1;
        TK_POINT: point_d = 1'b1;
        TK_DIGIT: begin
          if (too_large) begin
            raise_en   = 1'b1;
            raise_code = ST_TOO_LARGE;
          end else begin
            acc_d = prod[ValueW-1:0];
          end
        end
        default: begin
          raise_en   = 1'b1;
          raise_code = ST_BAD_CHAR;
        end
      endcase
    end

    err_d = err0;
    ebp_d = ebp0;
    if (raise_en && err0 == ST_OK) begin
      err_d = raise_code;
      ebp_d = ~point0;
    end

    priority if (err_d != ST_OK && ebp_d) begin
      st = err_d;
    end else if (point_d && cnt_d != {1'b0, cfg_i.fraction_digits}) begin
      st = ST_FRAC_LEN;
    end else begin
      st = err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      point_q     <= 1'b0;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      ebp_q       <= 1'b0;
      minus_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        if (tok_i.last) begin
          acc_q   <= '0;
          point_q <= 1'b0;
          cnt_q   <= '0;
          err_q   <= ST_OK;
          ebp_q   <= 1'b0;
          minus_q <= 1'b0;
        end else begin
          acc_q   <= acc_d;
          point_q <= point_d;
          cnt_q   <= cnt_d;
          err_q   <= err_d;
          ebp_q   <= ebp_d;
          minus_q <= minus_d;
        end
      end
      if (tok_pop_o && tok_i.last) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o && tok_i.last) begin
      res_mag_q <= (st == ST_OK) ? acc_d : '0;
      res_neg_q <= (st == ST_OK) ? minus_d : 1'b0;
      res_st_q  <= st;
    end
  end

endmodule

// ----- rtl/fixed_decimal_text_to_int_unit.sv -----
// Top level of the decimal text to scaled binary converter.
`timescale 1ns / 1ps
`include "fixed_decimal_text_to_int_unit_assert.svh"
// Usage:
//   Characters enter on a queue-style port: a request is taken when push is
//   high and full is low. first_char_i clears the running state, last_char_i
//   closes the string and produces one result. Characters without last give
//   no result.
//   Results leave on a queue-style port: magnitude, sign and status are valid
//   while empty is low and are taken when pop is high.
//   Throughput: one character per cycle, sustained while results are popped.
//   The last character is written into the token queue, then its result into
//   the output register, where empty falls. One multiply-by-ten, add and limit
//   compare in the back end set the cycle.
//   A four-entry token queue sits between classifier and accumulator. While
//   pop stays low, a waiting result holds the output register; non-last
//   characters still flow, and full rises once the queue is full behind a
//   last character.
//   Reset loads value_limit 2^63-1, fraction_digits 2, signed_mode 1 and
//   empties both sides. Registers at APB byte addresses 0, 8, 16; write only
//   while idle.
module fixed_decimal_text_to_int_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  char_code_i,
  input  logic                        first_char_i,
  input  logic                        last_char_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [fdti_pkg::ValueW-1:0] magnitude_o,
  output logic                        negative_o,
  output logic [2:0]                  status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import fdti_pkg::*;

  logic [ValueW-1:0] limit_q;
  logic [FracW-1:0]  frac_q;
  logic              signed_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  logic      q_wr, q_full, q_empty, q_rd;
  token_t    tok_in, tok_out;
  back_cfg_t back_cfg;
  status_e   status;
  logic      err_result_clean;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      frac_q   <= FRAC_RESET;
      signed_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_VALUE_LIMIT:     limit_q  <= pwdata;
        REG_FRACTION_DIGITS: frac_q   <= pwdata[FracW-1:0];
        REG_SIGNED_MODE:     signed_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VALUE_LIMIT:     prdata = limit_q;
      REG_FRACTION_DIGITS: prdata = {{(64-FracW){1'b0}}, frac_q};
      REG_SIGNED_MODE:     prdata = {63'b0, signed_q};
      default:             prdata = '0;
    endcase
  end

  assign back_cfg.value_limit     = limit_q;
  assign back_cfg.fraction_digits = frac_q;

  fdti_front u_front (
    .push_i        (push),
    .q_full_i      (q_full),
    .char_code_i   (char_code_i),
    .first_char_i  (first_char_i),
    .last_char_i   (last_char_i),
    .signed_mode_i (signed_q),
    .q_wr_o        (q_wr),
    .tok_o         (tok_in)
  );

  fdti_tok_fifo u_tok_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (tok_in),
    .full_o    (q_full),
    .rd_en_i   (q_rd),
    .rd_data_o (tok_out),
    .empty_o   (q_empty)
  );

  fdti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (back_cfg),
    .tok_valid_i (~q_empty),
    .tok_i       (tok_out),
    .tok_pop_o   (q_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .magnitude_o (magnitude_o),
    .negative_o  (negative_o),
    .status_o    (status)
  );

  assign full     = q_full;
  assign status_o = status;

  assign err_result_clean = empty || status == ST_OK || (magnitude_o == '0 && !negative_o);

  `FDTI_ASSERT(a_err_clears_payload, err_result_clean, "error result carries a payload")
  `FDTI_ASSERT(a_status_range, empty || status <= ST_TOO_LARGE, "status code out of range")
  `FDTI_ASSERT_NEXT(a_result_lands, q_rd && tok_out.last, !empty, "last token gave no result")
  `FDTI_ASSERT(a_no_pop_when_empty, !(q_rd && q_empty), "token read from empty queue")

endmodule
